// ===== sv/qte_pkg.sv =====
`default_nettype none
package qte_pkg;

  localparam int COMPONENT_WIDTH_DEF   = 16;
  localparam int CORDIC_ITERATIONS_DEF = 16;

  localparam int ACC_W    = 27;
  localparam int DEG180   = 11796480;
  localparam int LIM_FULL = 23040;
  localparam int LIM_HALF = 11520;
  localparam int YAW_W    = 16;
  localparam int PITCH_W  = 15;
  localparam int ROLL_W   = 16;
  localparam int QUEUE_DEPTH = 2;

  typedef struct packed {
    logic signed [YAW_W-1:0]   yaw;
    logic signed [PITCH_W-1:0] pitch;
    logic signed [ROLL_W-1:0]  roll;
    logic                      clamped;
  } qte_result_t;

  // atan(2^-i) in degrees scaled by 2^16, rounded to nearest.
  function automatic logic signed [ACC_W-1:0] atan_tab(input int i);
    logic signed [ACC_W-1:0] v;
    case (i)
      0:  v = ACC_W'(2949120);
      1:  v = ACC_W'(1740967);
      2:  v = ACC_W'(919879);
      3:  v = ACC_W'(466945);
      4:  v = ACC_W'(234379);
      5:  v = ACC_W'(117304);
      6:  v = ACC_W'(58666);
      7:  v = ACC_W'(29335);
      8:  v = ACC_W'(14668);
      9:  v = ACC_W'(7334);
      10: v = ACC_W'(3667);
      11: v = ACC_W'(1833);
      12: v = ACC_W'(917);
      13: v = ACC_W'(458);
      14: v = ACC_W'(229);
      15: v = ACC_W'(115);
      16: v = ACC_W'(57);
      17: v = ACC_W'(29);
      18: v = ACC_W'(14);
      19: v = ACC_W'(7);
      20: v = ACC_W'(4);
      21: v = ACC_W'(2);
      22: v = ACC_W'(1);
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

// ===== sv/qte_fifo.sv =====
`default_nettype none
module qte_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  output logic                  full_o,
  input  wire logic             pop_i,
  output logic                  empty_o,
  output logic [WIDTH-1:0]      rdata_o
);
  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PW-1:0]    wptr_q, rptr_q;
  logic [CW-1:0]    cnt_q;
  logic             do_push, do_pop;

  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign full_o  = (cnt_q == CW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign rdata_o = mem_q[rptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (do_push) begin
        wptr_q <= (wptr_q == PW'(DEPTH - 1)) ? '0 : wptr_q + 1'b1;
      end
      if (do_pop) begin
        rptr_q <= (rptr_q == PW'(DEPTH - 1)) ? '0 : rptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end
endmodule
`default_nettype wire

// ===== sv/qte_front.sv =====
`default_nettype none
module qte_front #(
  parameter int W = qte_pkg::COMPONENT_WIDTH_DEF
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                push_i,
  output logic                     full_o,
  input  wire logic signed [W-1:0] quat_x_i,
  input  wire logic signed [W-1:0] quat_y_i,
  input  wire logic signed [W-1:0] quat_z_i,
  input  wire logic signed [W-1:0] quat_w_i,
  input  wire logic                mid_full_i,
  output logic                     mid_push_o,
  output logic [4*(W+4)+W+1-1:0]   mid_data_o
);
  import qte_pkg::*;

  localparam int FRAC = W - 2;
  localparam int TW   = W + 3;
  localparam int NW   = W + 4;
  localparam int SW   = FRAC + 2;
  localparam logic signed [NW-1:0] ONE = NW'(1) << FRAC;

  logic signed [TW-1:0] wz_q, xy_q, yy_q, zz_q, wx_q, yz_q, xx_q, wy_q, zx_q;
  logic signed [NW-1:0] yaw_n_q, yaw_d_q, roll_n_q, roll_d_q;
  logic signed [NW-1:0] s_raw;
  logic signed [SW-1:0] s_q;
  logic                 clamp_q;
  logic                 v1_q, v2_q, adv;

  function automatic logic signed [TW-1:0] twice(input logic signed [W-1:0] a,
                                                 input logic signed [W-1:0] b);
    logic signed [2*W-1:0] p;
    logic signed [2*W-1:0] sh;
    p  = a * b;
    sh = p >>> (FRAC - 1);
    return sh[TW-1:0];
  endfunction

  assign adv        = !(v2_q && mid_full_i);
  assign full_o     = !adv;
  assign mid_push_o = v2_q && !mid_full_i;
  assign s_raw      = NW'(wy_q) - NW'(zx_q);
  assign mid_data_o = {yaw_n_q, yaw_d_q, roll_n_q, roll_d_q, s_q, clamp_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else if (adv) begin
      v1_q <= push_i;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      wz_q <= twice(quat_w_i, quat_z_i);
      xy_q <= twice(quat_x_i, quat_y_i);
      yy_q <= twice(quat_y_i, quat_y_i);
      zz_q <= twice(quat_z_i, quat_z_i);
      wx_q <= twice(quat_w_i, quat_x_i);
      yz_q <= twice(quat_y_i, quat_z_i);
      xx_q <= twice(quat_x_i, quat_x_i);
      wy_q <= twice(quat_w_i, quat_y_i);
      zx_q <= twice(quat_z_i, quat_x_i);
      yaw_n_q  <= NW'(wz_q) + NW'(xy_q);
      yaw_d_q  <= ONE - (NW'(yy_q) + NW'(zz_q));
      roll_n_q <= NW'(wx_q) + NW'(yz_q);
      roll_d_q <= ONE - (NW'(xx_q) + NW'(yy_q));
      if (s_raw > ONE) begin
        s_q     <= SW'(ONE);
        clamp_q <= 1'b1;
      end else if (s_raw < -ONE) begin
        s_q     <= SW'(-ONE);
        clamp_q <= 1'b1;
      end else begin
        s_q     <= SW'(s_raw);
        clamp_q <= 1'b0;
      end
    end
  end
endmodule
`default_nettype wire

// ===== sv/qte_cordic.sv =====
`default_nettype none
module qte_cordic #(
  parameter int IW  = 20,
  parameter int N   = qte_pkg::CORDIC_ITERATIONS_DEF,
  parameter int OW  = 16,
  parameter int LIM = qte_pkg::LIM_FULL
) (
  input  wire logic                 clk_i,
  input  wire logic                 en_i,
  input  wire logic signed [IW-1:0] n_i,
  input  wire logic signed [IW-1:0] d_i,
  output logic signed [OW-1:0]      angle_o
);
  import qte_pkg::*;

  localparam int CW = IW + 2;
  localparam logic signed [ACC_W-1:0] D180 = ACC_W'(DEG180);
  localparam logic signed [ACC_W-1:0] LIMV = ACC_W'(LIM);

  logic signed [CW-1:0]    n_q   [N+1];
  logic signed [CW-1:0]    d_q   [N+1];
  logic signed [ACC_W-1:0] acc_q [N+1];
  logic                    zero_q[N+1];
  logic signed [ACC_W-1:0] rnd;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      zero_q[0] <= (n_i == '0) && (d_i == '0);
      if (d_i < 0) begin
        n_q[0]   <= -CW'(n_i);
        d_q[0]   <= -CW'(d_i);
        acc_q[0] <= (n_i >= 0) ? D180 : -D180;
      end else begin
        n_q[0]   <= CW'(n_i);
        d_q[0]   <= CW'(d_i);
        acc_q[0] <= '0;
      end
    end
  end

  for (genvar i = 0; i < N; i++) begin : g_iter
    logic signed [CW-1:0] nn, dd;
    assign nn = n_q[i] >>> i;
    assign dd = d_q[i] >>> i;
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        zero_q[i+1] <= zero_q[i];
        if (!n_q[i][CW-1]) begin
          d_q[i+1]   <= d_q[i] + nn;
          n_q[i+1]   <= n_q[i] - dd;
          acc_q[i+1] <= acc_q[i] + atan_tab(i);
        end else begin
          d_q[i+1]   <= d_q[i] - nn;
          n_q[i+1]   <= n_q[i] + dd;
          acc_q[i+1] <= acc_q[i] - atan_tab(i);
        end
      end
    end
  end

  assign rnd = (acc_q[N] + ACC_W'(256)) >>> 9;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (zero_q[N]) begin
        angle_o <= '0;
      end else if (rnd > LIMV) begin
        angle_o <= OW'(LIMV);
      end else if (rnd < -LIMV) begin
        angle_o <= OW'(-LIMV);
      end else begin
        angle_o <= OW'(rnd);
      end
    end
  end
endmodule
`default_nettype wire

// ===== sv/qte_back.sv =====
`default_nettype none
module qte_back #(
  parameter int W = qte_pkg::COMPONENT_WIDTH_DEF,
  parameter int N = qte_pkg::CORDIC_ITERATIONS_DEF
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     mid_empty_i,
  input  wire logic [4*(W+4)+W+1-1:0]   mid_data_i,
  output logic                          mid_pop_o,
  input  wire logic                     out_full_i,
  output logic                          out_push_o,
  output qte_pkg::qte_result_t          out_data_o
);
  import qte_pkg::*;

  localparam int FRAC = W - 2;
  localparam int NW   = W + 4;
  localparam int SW   = FRAC + 2;
  localparam int MW   = 4 * NW + SW + 1;
  localparam int RB   = FRAC + 1;
  localparam int TW   = 2 * RB + 1;
  localparam int CL   = N + 2;
  localparam logic [TW-1:0] ONE2 = TW'(1) << (2 * FRAC);

  logic [TW-1:0] rem_q  [RB+1];
  logic [RB-1:0] root_q [RB+1];
  logic [MW-1:0] car_q  [RB+1];
  logic          vld_q  [RB+1];
  logic          vldc_q [CL];
  logic          clmp_q [CL];
  logic          adv;

  logic signed [SW-1:0]   s_in;
  logic signed [2*SW-1:0] sq;
  logic signed [NW-1:0]   yaw_n, yaw_d, roll_n, roll_d, p_n, p_d;
  logic signed [SW-1:0]   s_end;
  logic signed [YAW_W-1:0]   yaw;
  logic signed [PITCH_W-1:0] pitch;
  logic signed [ROLL_W-1:0]  roll;

  assign adv        = !(vldc_q[CL-1] && out_full_i);
  assign mid_pop_o  = adv && !mid_empty_i;
  assign out_push_o = vldc_q[CL-1] && !out_full_i;

  assign s_in = mid_data_i[SW:1];
  assign sq   = s_in * s_in;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k <= RB; k++) vld_q[k] <= 1'b0;
      for (int k = 0; k < CL; k++) vldc_q[k] <= 1'b0;
    end else if (adv) begin
      vld_q[0] <= !mid_empty_i;
      for (int k = 0; k < RB; k++) vld_q[k+1] <= vld_q[k];
      vldc_q[0] <= vld_q[RB];
      for (int k = 1; k < CL; k++) vldc_q[k] <= vldc_q[k-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      rem_q[0]  <= ONE2 - sq[TW-1:0];
      root_q[0] <= '0;
      car_q[0]  <= mid_data_i;
      clmp_q[0] <= car_q[RB][0];
      for (int k = 1; k < CL; k++) clmp_q[k] <= clmp_q[k-1];
    end
  end

  for (genvar k = 0; k < RB; k++) begin : g_sqrt
    localparam int B = RB - 1 - k;
    logic [TW-1:0] t;
    assign t = (TW'(root_q[k]) << (B + 1)) + (TW'(1) << (2 * B));
    always_ff @(posedge clk_i) begin
      if (adv) begin
        car_q[k+1] <= car_q[k];
        if (rem_q[k] >= t) begin
          rem_q[k+1]  <= rem_q[k] - t;
          root_q[k+1] <= root_q[k] | (RB'(1) << B);
        end else begin
          rem_q[k+1]  <= rem_q[k];
          root_q[k+1] <= root_q[k];
        end
      end
    end
  end

  assign yaw_n  = car_q[RB][MW-1 -: NW];
  assign yaw_d  = car_q[RB][MW-NW-1 -: NW];
  assign roll_n = car_q[RB][MW-2*NW-1 -: NW];
  assign roll_d = car_q[RB][MW-3*NW-1 -: NW];
  assign s_end  = car_q[RB][SW:1];
  assign p_n    = NW'(s_end);
  assign p_d    = {{(NW-RB){1'b0}}, root_q[RB]};

  qte_cordic #(.IW(NW), .N(N), .OW(YAW_W), .LIM(LIM_FULL)) u_yaw (
    .clk_i(clk_i), .en_i(adv), .n_i(yaw_n), .d_i(yaw_d), .angle_o(yaw)
  );
  qte_cordic #(.IW(NW), .N(N), .OW(PITCH_W), .LIM(LIM_HALF)) u_pitch (
    .clk_i(clk_i), .en_i(adv), .n_i(p_n), .d_i(p_d), .angle_o(pitch)
  );
  qte_cordic #(.IW(NW), .N(N), .OW(ROLL_W), .LIM(LIM_FULL)) u_roll (
    .clk_i(clk_i), .en_i(adv), .n_i(roll_n), .d_i(roll_d), .angle_o(roll)
  );

  always_comb begin
    out_data_o.yaw     = yaw;
    out_data_o.pitch   = pitch;
    out_data_o.roll    = roll;
    out_data_o.clamped = clmp_q[CL-1];
  end
endmodule
`default_nettype wire

// ===== sv/quaternion_to_euler_angles.sv =====
// Channel | Handshake    | Payload
// input   | push / full  | quat_x_i, quat_y_i, quat_z_i, quat_w_i
// result  | empty / pop  | yaw_angle_o, pitch_angle_o, roll_angle_o, pitch_clamped_o
//
// One item is accepted per cycle while full is low; throughput is set by the fully pipelined
// square root and the three CORDIC pipelines, one stage per step.
// Items pass through the front registers, middle queue, square root, CORDICs and result queue.
// Reset is asynchronous and empties both queues and all pipelines.
// A stalled result side holds the back pipeline; the front fills its queue and then sets full.
`default_nettype none
module quaternion_to_euler_angles #(
  parameter int COMPONENT_WIDTH   = qte_pkg::COMPONENT_WIDTH_DEF,
  parameter int CORDIC_ITERATIONS = qte_pkg::CORDIC_ITERATIONS_DEF
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              push,
  output logic                                   full,
  input  wire logic signed [COMPONENT_WIDTH-1:0] quat_x_i,
  input  wire logic signed [COMPONENT_WIDTH-1:0] quat_y_i,
  input  wire logic signed [COMPONENT_WIDTH-1:0] quat_z_i,
  input  wire logic signed [COMPONENT_WIDTH-1:0] quat_w_i,
  output logic                                   empty,
  input  wire logic                              pop,
  output logic signed [qte_pkg::YAW_W-1:0]       yaw_angle_o,
  output logic signed [qte_pkg::PITCH_W-1:0]     pitch_angle_o,
  output logic signed [qte_pkg::ROLL_W-1:0]      roll_angle_o,
  output logic                                   pitch_clamped_o
);
  import qte_pkg::*;

  localparam int W  = COMPONENT_WIDTH;
  localparam int MW = 4 * (W + 4) + W + 1;
  localparam int RW = $bits(qte_result_t);

  logic          mid_push, mid_full, mid_pop, mid_empty;
  logic [MW-1:0] mid_wdata, mid_rdata;
  logic          out_push, out_full;
  qte_result_t   out_wdata, out_rdata;

  qte_front #(.W(W)) u_front (
    .clk_i(clk_i), .rst_ni(rst_ni), .push_i(push), .full_o(full),
    .quat_x_i(quat_x_i), .quat_y_i(quat_y_i), .quat_z_i(quat_z_i), .quat_w_i(quat_w_i),
    .mid_full_i(mid_full), .mid_push_o(mid_push), .mid_data_o(mid_wdata)
  );

  qte_fifo #(.WIDTH(MW), .DEPTH(QUEUE_DEPTH)) u_mid_q (
    .clk_i(clk_i), .rst_ni(rst_ni), .push_i(mid_push), .wdata_i(mid_wdata),
    .full_o(mid_full), .pop_i(mid_pop), .empty_o(mid_empty), .rdata_o(mid_rdata)
  );

  qte_back #(.W(W), .N(CORDIC_ITERATIONS)) u_back (
    .clk_i(clk_i), .rst_ni(rst_ni), .mid_empty_i(mid_empty), .mid_data_i(mid_rdata),
    .mid_pop_o(mid_pop), .out_full_i(out_full), .out_push_o(out_push),
    .out_data_o(out_wdata)
  );

  qte_fifo #(.WIDTH(RW), .DEPTH(QUEUE_DEPTH)) u_out_q (
    .clk_i(clk_i), .rst_ni(rst_ni), .push_i(out_push), .wdata_i(out_wdata),
    .full_o(out_full), .pop_i(pop), .empty_o(empty), .rdata_o(out_rdata)
  );

  assign yaw_angle_o     = out_rdata.yaw;
  assign pitch_angle_o   = out_rdata.pitch;
  assign roll_angle_o    = out_rdata.roll;
  assign pitch_clamped_o = out_rdata.clamped;

  a_yaw_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> (yaw_angle_o <= 16'sd23040) && (yaw_angle_o >= -16'sd23040))
    else $error("yaw out of range");

  a_pitch_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> (pitch_angle_o <= 15'sd11520) && (pitch_angle_o >= -15'sd11520))
    else $error("pitch out of range");

  a_roll_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> (roll_angle_o <= 16'sd23040) && (roll_angle_o >= -16'sd23040))
    else $error("roll out of range");

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(out_push && out_full) && !(mid_push && mid_full))
    else $error("queue written while full");
endmodule
`default_nettype wire
